### rtl/core/slt_pkg.sv
// ============================================================================
// slt_pkg - shared types and codes for the sorted list table
// Action and status codes, cell command set and cell control word.
// ============================================================================
`timescale 1ns / 1ps

package slt_pkg;

    localparam int DATA_W = 32;

    // request actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_DEDUPE = 2'd2;
    localparam logic [1:0] ACT_DUMP   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // what each cell flags on the search chain
    typedef enum logic [1:0] {
        SCAN_INS,
        SCAN_DEL,
        SCAN_DUP
    } t_scan;

    // what each cell does at the next edge
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE,
        CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_scan              scan;
        t_cmd               cmd;
        logic               descending;
        logic [DATA_W-1:0]  operand;
    } t_cell_ctrl;

endpackage

### rtl/core/slt_cell.sv
// ============================================================================
// slt_cell - one slot of the sorted list table
// Holds one entry and its duplicate mark; compares against the broadcast
// operand, joins the first-hit chain and shifts or rotates with neighbours.
// ============================================================================
`timescale 1ns / 1ps

module slt_cell (
    input  logic                        i_clk,
    input  slt_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_valid,
    input  logic                        i_tail,
    input  logic                        i_first_free,
    input  logic                        i_mark_en,
    input  logic [slt_pkg::DATA_W-1:0]  i_left_entry,
    input  logic                        i_left_dup,
    input  logic [slt_pkg::DATA_W-1:0]  i_right_entry,
    input  logic                        i_right_dup,
    input  logic [slt_pkg::DATA_W-1:0]  i_head_entry,
    input  logic                        i_head_dup,
    input  logic                        i_hit,
    output logic                        o_hit,
    output logic                        o_first,
    output logic [slt_pkg::DATA_W-1:0]  o_entry,
    output logic                        o_dup
);
    import slt_pkg::*;

    logic [DATA_W-1:0] r_entry, n_entry;
    logic              r_dup, n_dup;
    logic              w_eq, w_ahead, w_flag;

    assign w_eq    = (r_entry == i_ctrl.operand);
    assign w_ahead = i_ctrl.descending ? ($signed(r_entry) > $signed(i_ctrl.operand))
                                       : ($signed(r_entry) < $signed(i_ctrl.operand));

    always_comb begin
        case (i_ctrl.scan)
            SCAN_INS: w_flag = (i_valid & ~w_ahead) | i_first_free;
            SCAN_DEL: w_flag = i_valid & w_eq;
            SCAN_DUP: w_flag = i_valid & r_dup;
            default:  w_flag = 1'b0;
        endcase
    end

    assign o_hit   = i_hit | w_flag;
    assign o_first = w_flag & ~i_hit;
    assign o_entry = r_entry;
    // mark travels with the entry as it rotates
    assign o_dup   = r_dup | (i_mark_en & w_eq);

    always_comb begin
        n_entry = r_entry;
        n_dup   = r_dup;
        case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (o_first) begin
                    n_entry = i_ctrl.operand;
                    n_dup   = 1'b0;
                end else if (i_hit) begin
                    n_entry = i_left_entry;
                    n_dup   = i_left_dup;
                end
            end
            CMD_REMOVE: begin
                if (o_hit) begin
                    n_entry = i_right_entry;
                    n_dup   = i_right_dup;
                end
            end
            CMD_ROTATE: begin
                if (i_valid && i_tail) begin
                    n_entry = i_head_entry;
                    n_dup   = i_head_dup;
                end else if (i_valid) begin
                    n_entry = i_right_entry;
                    n_dup   = i_right_dup;
                end
            end
            CMD_CLEAR: n_dup = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_dup   <= n_dup;
    end

endmodule

### rtl/core/sorted_list_table_unit.sv
// ============================================================================
// sorted_list_table_unit - insert/delete/dedupe/dump on an ordered table
// Insert, delete and errors: result registered from S_EXEC; next request once back in S_IDLE.
// Dump: first entry after S_EXEC and S_DUMP, then one per cycle unless output stalls (count words).
// Dedupe: result after the mark rotation (S_MARK) and removal of each duplicate (S_PACK).
// Sync active-low reset empties the table and clears mode; no clearing pass.
// ============================================================================
`timescale 1ns / 1ps

// The table is a row of CAPACITY cells. Every cycle each cell compares its
// entry against one broadcast operand and joins a ripple chain that finds the
// first flagged slot. Insert shifts the cells after that slot right, delete
// shifts them left. Dump rotates the occupied cells once per word and reads
// cell 0, so after a full dump the table is back in place. Dedupe rotates the
// table count times, broadcasting cell 0 and marking later equal entries;
// marked cells are then squeezed out one per cycle.
// One request is worked at a time; the shared search chain and the rotation
// through cell 0 set the order of steps described above.

module sorted_list_table_unit #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] entry_value, [36:32] entry_position,
                                          // [42:37] entry_count, [47:43] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast,   // last
    // mode register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data        // [0] descending_mode
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DUMP = 5'b00100,
        S_MARK = 5'b01000,
        S_PACK = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_idx, n_idx;
    logic [1:0]         r_action;
    logic [DATA_W-1:0]  r_value;
    logic               r_descending;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [DATA_W-1:0]  r_out_value;
    logic [4:0]         r_out_pos;
    logic [5:0]         r_out_count;
    logic               r_out_last;

    logic               w_s_accept, w_out_free;
    logic               w_emit, w_e_last;
    logic [1:0]         w_e_status;
    logic [DATA_W-1:0]  w_e_value;
    logic [4:0]         w_e_pos;
    logic [CW-1:0]      w_e_count;
    t_cmd               w_cmd;
    t_scan              w_scan;
    t_cell_ctrl         w_ctrl;
    logic [CW-1:0]      w_rem;

    // cell row wiring
    logic [DATA_W-1:0]  w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_dup;
    logic [CAPACITY:0]  w_hit;
    logic [CAPACITY-1:0] w_first;
    logic               w_found;
    logic [IW-1:0]      w_pos;

    assign w_s_accept      = i_s_axis_tvalid & o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_out_free      = ~r_out_valid | i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign w_hit[0] = 1'b0;
    assign w_found  = w_hit[CAPACITY];
    // entries left to compare against the current head while marking
    assign w_rem    = r_count - CW'(1) - CW'(r_idx);

    assign w_ctrl.scan       = w_scan;
    assign w_ctrl.cmd        = w_cmd;
    assign w_ctrl.descending = r_descending;
    assign w_ctrl.operand    = (r_state == S_MARK) ? w_entry[0] : r_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left_e, w_right_e;
        logic              w_left_d, w_right_d;

        if (g == 0) begin : g_head
            assign w_left_e = '0;
            assign w_left_d = 1'b0;
        end else begin : g_mid
            assign w_left_e = w_entry[g-1];
            assign w_left_d = w_dup[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right_e = '0;
            assign w_right_d = 1'b0;
        end else begin : g_inner
            assign w_right_e = w_entry[g+1];
            assign w_right_d = w_dup[g+1];
        end

        slt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_valid       (CW'(g) < r_count),
            .i_tail        (CW'(g) == r_count - CW'(1)),
            .i_first_free  (CW'(g) == r_count),
            .i_mark_en     ((r_state == S_MARK) && (g != 0) && (CW'(g) <= w_rem)),
            .i_left_entry  (w_left_e),
            .i_left_dup    (w_left_d),
            .i_right_entry (w_right_e),
            .i_right_dup   (w_right_d),
            .i_head_entry  (w_entry[0]),
            .i_head_dup    (w_dup[0]),
            .i_hit         (w_hit[g]),
            .o_hit         (w_hit[g+1]),
            .o_first       (w_first[g]),
            .o_entry       (w_entry[g]),
            .o_dup         (w_dup[g])
        );
    end

    // at most one first-hit bit is set
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) w_pos = w_pos | IW'(i);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        w_emit     = 1'b0;
        w_e_status = ST_OK;
        w_e_value  = '0;
        w_e_pos    = '0;
        w_e_count  = r_count;
        w_e_last   = 1'b1;
        w_cmd      = CMD_HOLD;
        w_scan     = SCAN_INS;

        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                w_scan = (r_action == ACT_DELETE) ? SCAN_DEL : SCAN_INS;
                case (r_action)
                    ACT_INSERT: begin
                        if (w_out_free) begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == CW'(CAPACITY)) begin
                                w_e_status = ST_FULL;
                            end else begin
                                w_cmd     = CMD_INSERT;
                                n_count   = r_count + CW'(1);
                                w_e_count = r_count + CW'(1);
                                w_e_pos   = 5'(w_pos);
                            end
                        end
                    end
                    ACT_DELETE: begin
                        if (w_out_free) begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == '0) begin
                                w_e_status = ST_EMPTY;
                            end else if (!w_found) begin
                                w_e_status = ST_NOT_FOUND;
                            end else begin
                                w_cmd     = CMD_REMOVE;
                                n_count   = r_count - CW'(1);
                                w_e_count = r_count - CW'(1);
                                w_e_pos   = 5'(w_pos);
                            end
                        end
                    end
                    ACT_DEDUPE, ACT_DUMP: begin
                        if (r_count == '0) begin
                            if (w_out_free) begin
                                w_emit     = 1'b1;
                                w_e_status = ST_EMPTY;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            n_idx = '0;
                            if (r_action == ACT_DEDUPE) begin
                                w_cmd   = CMD_CLEAR;
                                n_state = S_MARK;
                            end else begin
                                n_state = S_DUMP;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_emit    = 1'b1;
                    w_cmd     = CMD_ROTATE;
                    w_e_value = w_entry[0];
                    w_e_pos   = 5'(r_idx);
                    w_e_last  = (CW'(r_idx) == r_count - CW'(1));
                    n_idx     = r_idx + IW'(1);
                    if (w_e_last) n_state = S_IDLE;
                end
            end
            S_MARK: begin
                w_cmd = CMD_ROTATE;
                n_idx = r_idx + IW'(1);
                if (CW'(r_idx) == r_count - CW'(1)) n_state = S_PACK;
            end
            S_PACK: begin
                w_scan = SCAN_DUP;
                if (w_found) begin
                    // squeeze out the first marked entry
                    w_cmd   = CMD_REMOVE;
                    n_count = r_count - CW'(1);
                end else if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_descending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            if (i_cfg_valid && o_cfg_ready) r_descending <= i_cfg_data[0];
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_action <= i_s_axis_tuser;
            r_value  <= i_s_axis_tdata;
        end
        if (w_emit) begin
            r_out_status <= w_e_status;
            r_out_value  <= w_e_value;
            r_out_pos    <= w_e_pos;
            r_out_count  <= 6'(w_e_count);
            r_out_last   <= w_e_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_count, r_out_pos, r_out_value};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_cmd == CMD_INSERT) |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the table by one");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == CMD_REMOVE) |-> (r_count != '0))
        else $error("remove on an empty table");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && w_emit && w_e_last) |=> r_state == S_IDLE)
        else $error("dump did not finish after its last word");
`endif

endmodule
